FILE: hw/rtl/sprb_pkg.sv
// Shared types and constants for the SPI master ring buffer core.
// No dependencies; imported by sprb_ctrl, sprb_dp and the top level.
package sprb_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;

    // Operation codes carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 2'd0,
        OP_TRIGGER   = 2'd1,
        OP_XFER_DONE = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic exec;     // input beat accepted: update pointers, issue RAM access
        logic capture;  // RAM read data valid: load result register
    } cmd_t;

    // One result item
    typedef struct packed {
        logic              load_dropped;
        logic              read_short;
        logic [BYTE_W-1:0] read_data;
        logic [BYTE_W-1:0] send_byte;
        logic              send_valid;
    } result_t;

endpackage

FILE: hw/rtl/sprb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sprb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sprb_ctrl.sv
// Controller state machine: sequences accept, RAM fetch and result beat.
// Depends on sprb_pkg.
module sprb_ctrl
    import sprb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and outputs
    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/sprb_dp.sv
// Datapath: ring pointers, occupancy math, both ring RAMs, result register.
// Depends on sprb_pkg and sprb_ram.
module sprb_dp
    import sprb_pkg::*;
#(
    parameter int BUF_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  op_t               op,
    input  logic [BYTE_W-1:0] tx_byte,
    input  logic [BYTE_W-1:0] count,
    input  logic [BYTE_W-1:0] received_byte,
    output result_t           result
);

    localparam int PW = $clog2(BUF_DEPTH);
    // sum width: pointer plus an 8-bit count never exceeds 9 bits
    localparam int SW = BYTE_W + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(BUF_DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(BUF_DEPTH - 1);

    logic [PW-1:0] tx_head_reg, tx_head_next;
    logic [PW-1:0] tx_tail_reg, tx_tail_next;
    logic [PW-1:0] rx_head_reg, rx_head_next;
    logic [PW-1:0] rx_tail_reg, rx_tail_next;

    logic send_reg, send_next;
    logic rdok_reg, rdok_next;
    logic short_reg, short_next;
    logic drop_reg, drop_next;
    result_t result_reg;

    logic              tx_we, tx_re, rx_we, rx_re;
    logic [PW-1:0]     rx_raddr;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    logic              tx_empty;
    logic [BYTE_W-1:0] n;
    logic              n_ok;
    logic [SW-1:0]     have;
    logic [SW-1:0]     addr_sum, tail_sum;
    logic [PW-1:0]     rx_tail_adv;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == LAST_P) ? '0 : p + PW'(1);
    endfunction

    // occupancy and read offsets
    always_comb
    begin
        tx_empty = (tx_head_reg == tx_tail_reg);
        n        = (count == '0) ? BYTE_W'(1) : count;
        n_ok     = ({1'b0, n} <= DEPTH_S);
        have     = SW'(rx_head_reg) - SW'(rx_tail_reg)
                 + ((rx_head_reg < rx_tail_reg) ? DEPTH_S : '0);
        addr_sum = SW'(rx_tail_reg) + {1'b0, n} - SW'(1);
        if (addr_sum >= DEPTH_S)
        begin
            addr_sum = addr_sum - DEPTH_S;
        end
        rx_raddr = addr_sum[PW-1:0];
        tail_sum = SW'(rx_tail_reg) + {1'b0, n};
        if (tail_sum >= DEPTH_S)
        begin
            tail_sum = tail_sum - DEPTH_S;
        end
        rx_tail_adv = tail_sum[PW-1:0];
    end

    // operation decode
    always_comb
    begin
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        send_next    = send_reg;
        rdok_next    = rdok_reg;
        short_next   = short_reg;
        drop_next    = drop_reg;
        tx_we        = 1'b0;
        tx_re        = 1'b0;
        rx_we        = 1'b0;
        rx_re        = 1'b0;
        if (cmd.exec)
        begin
            send_next  = 1'b0;
            rdok_next  = 1'b0;
            short_next = 1'b0;
            drop_next  = 1'b0;
            unique case (op)
                OP_LOAD:
                begin
                    if ({1'b0, count} > DEPTH_S)
                    begin
                        drop_next = 1'b1;
                    end
                    else if (count != '0)
                    begin
                        tx_we        = 1'b1;
                        tx_head_next = ptr_inc(tx_head_reg);
                    end
                end
                OP_TRIGGER, OP_XFER_DONE:
                begin
                    if (!tx_empty)
                    begin
                        if (op == OP_XFER_DONE)
                        begin
                            rx_we        = 1'b1;
                            rx_head_next = ptr_inc(rx_head_reg);
                        end
                        tx_re        = 1'b1;
                        send_next    = 1'b1;
                        tx_tail_next = ptr_inc(tx_tail_reg);
                    end
                end
                OP_READ:
                begin
                    if (!n_ok)
                    begin
                        short_next = 1'b1;
                    end
                    else if (have >= {1'b0, n})
                    begin
                        rx_re        = 1'b1;
                        rdok_next    = 1'b1;
                        rx_tail_next = rx_tail_adv;
                    end
                    else
                    begin
                        rx_tail_next = rx_head_reg;
                        short_next   = 1'b1;
                    end
                end
                default:
                begin
                    short_next = 1'b0;
                end
            endcase
        end
    end

    // pointer and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
        end
        else
        begin
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        send_reg  <= send_next;
        rdok_reg  <= rdok_next;
        short_reg <= short_next;
        drop_reg  <= drop_next;
    end

    // result register, loaded when RAM data lands
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            result_reg.send_valid   <= send_reg;
            result_reg.send_byte    <= send_reg ? tx_rdata : '0;
            result_reg.read_data    <= rdok_reg ? rx_rdata : '0;
            result_reg.read_short   <= short_reg;
            result_reg.load_dropped <= drop_reg;
        end
    end

    assign result = result_reg;

    // transmit ring
    sprb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (tx_byte),
        .re    (tx_re),
        .raddr (tx_tail_reg),
        .rdata (tx_rdata)
    );

    // receive ring
    sprb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (received_byte),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

endmodule

FILE: hw/rtl/spi_master_ring_buffers_core.sv
// Top level of the SPI master transmit/receive ring buffer core.
// Depends on sprb_pkg, sprb_ctrl, sprb_dp (and sprb_ram through sprb_dp).
//
// One input beat carries one operation (load, trigger, transfer done, read)
// and yields exactly one result beat. An item passes through the controller
// states in turn: ST_IDLE accepts it, updates the pointers and issues the
// ring RAM access; ST_FETCH picks up the registered RAM read data into the
// result register; ST_OUT presents the result until m_tready. The next beat
// is taken once the result beat has been accepted, so no new item is taken
// while one is in flight. Both rings hold BUF_DEPTH bytes; their contents
// are undefined until written, and no clearing pass runs after reset.
module spi_master_ring_buffers_core
    import sprb_pkg::*;
#(
    parameter int BUF_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] tx_byte, [15:8] count, [23:16] received_byte
    input  logic [23:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] send_valid, [8:1] send_byte, [16:9] read_data, [17] read_short,
    // [18] load_dropped, [23:19] zero
    output logic [23:0] m_tdata
);

    cmd_t    cmd;
    result_t result;

    sprb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sprb_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (op_t'(s_tuser)),
        .tx_byte       (s_tdata[7:0]),
        .count         (s_tdata[15:8]),
        .received_byte (s_tdata[23:16]),
        .result        (result)
    );

    // pack result beat, lowest field first
    assign m_tdata = {5'b0, result};

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for spi_master_ring_buffers_core: directed table, then random
// load/shift/read bursts and noise items. Depends on sprb_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
    import sprb_pkg::*;

    localparam int RING_DEPTH   = 32;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 27;

    localparam result_t RES_NONE  = '0;
    localparam result_t RES_SHORT = '{load_dropped: 1'b0, read_short: 1'b1,
                                      read_data: 8'h00, send_byte: 8'h00,
                                      send_valid: 1'b0};
    localparam result_t RES_DROP  = '{load_dropped: 1'b1, read_short: 1'b0,
                                      read_data: 8'h00, send_byte: 8'h00,
                                      send_valid: 1'b0};

    typedef struct {
        op_t       op;
        logic [7:0] txb;
        logic [7:0] cnt;
        logic [7:0] rcv;
        bit        typed;   // use the literal result below, not the predictor
        result_t   want;
    } stim_row_t;

    localparam int DIRECTED = 22;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    // Predictor state: both rings and their pointers
    logic [7:0] tx_ring [RING_DEPTH];
    logic [7:0] rx_ring [RING_DEPTH];
    int         tx_wr, tx_rd, rx_wr, rx_rd;

    result_t    owed_results[$];
    stim_row_t  plan [DIRECTED];
    int         items_sent;
    int         results_seen;
    int         errors;
    int         cycles;
    int         hold_left;
    bit         hold_done;

    spi_master_ring_buffers_core #(
        .BUF_DEPTH (RING_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run-length guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still owed", $time, owed_results.size());
            $display("spi_master_ring_buffers_core verification failed");
            $finish;
        end
    end

    // One operation on the predicted rings; returns the result beat it yields
    function automatic result_t ring_step(op_t op, logic [7:0] txb, logic [7:0] cnt,
                                          logic [7:0] rcv);
        result_t res;
        int      n;
        int      held;
        res = '0;
        case (op)
            OP_LOAD:
            begin
                if (cnt > RING_DEPTH)
                    res.load_dropped = 1'b1;
                else if (cnt != 0)
                begin
                    tx_ring[tx_wr] = txb;
                    tx_wr = (tx_wr + 1) % RING_DEPTH;
                end
            end
            OP_TRIGGER, OP_XFER_DONE:
            begin
                // nothing moves on an empty transmit ring
                if (tx_wr != tx_rd)
                begin
                    if (op == OP_XFER_DONE)
                    begin
                        rx_ring[rx_wr] = rcv;
                        rx_wr = (rx_wr + 1) % RING_DEPTH;
                    end
                    res.send_valid = 1'b1;
                    res.send_byte  = tx_ring[tx_rd];
                    tx_rd = (tx_rd + 1) % RING_DEPTH;
                end
            end
            default:
            begin
                n = (cnt == 0) ? 1 : int'(cnt);
                held = (rx_wr - rx_rd + RING_DEPTH) % RING_DEPTH;
                if (n > RING_DEPTH)
                    res.read_short = 1'b1;
                else if (held >= n)
                begin
                    res.read_data = rx_ring[(rx_rd + n - 1) % RING_DEPTH];
                    rx_rd = (rx_rd + n) % RING_DEPTH;
                end
                else
                begin
                    // ring runs short: drain it
                    rx_rd = rx_wr;
                    res.read_short = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    // Offer one beat, wait for it to be taken, then queue its expected result
    task automatic send_item(input op_t op, input logic [7:0] txb, input logic [7:0] cnt,
                             input logic [7:0] rcv, input bit typed, input result_t want);
        result_t predicted;
        bit      calm;
        calm = (items_sent >= 300) && (items_sent < 450);
        while (!calm && ($urandom_range(99) < IDLE_PCT))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rcv, cnt, txb};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = ring_step(op, txb, cnt, rcv);
        owed_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Well-formed burst: fill tx, shift some bytes through, read rx back
    task automatic run_burst();
        int         nload, nmove, nread, held, pick;
        logic [7:0] cnt;
        op_t        op;
        nload = ($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 10);
        repeat (nload)
        begin
            pick = $urandom_range(19);
            cnt  = (pick == 0) ? 8'($urandom_range(33, 255)) :
                   (pick == 1) ? 8'h00 : 8'($urandom_range(1, RING_DEPTH));
            send_item(OP_LOAD, 8'($urandom), cnt, 8'($urandom), 1'b0, RES_NONE);
        end
        nmove = $urandom_range(1, nload + 2);
        repeat (nmove)
        begin
            op = ($urandom_range(4) == 0) ? OP_TRIGGER : OP_XFER_DONE;
            send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, RES_NONE);
        end
        nread = $urandom_range(1, 3);
        repeat (nread)
        begin
            held = (rx_wr - rx_rd + RING_DEPTH) % RING_DEPTH;
            pick = $urandom_range(99);
            if (pick < 60)
                cnt = 8'($urandom_range(1, (held > 0) ? held : 1));
            else if (pick < 75)
                cnt = 8'h00;
            else if (pick < 90)
                cnt = 8'($urandom_range((held < RING_DEPTH) ? held + 1 : RING_DEPTH,
                                        RING_DEPTH));
            else
                cnt = 8'($urandom_range(RING_DEPTH + 1, 255));
            send_item(OP_READ, 8'($urandom), cnt, 8'($urandom), 1'b0, RES_NONE);
        end
    endtask

    task automatic field_err(input string name, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    endtask

    // Compare one result beat with the oldest owed result
    task automatic check_beat(input logic [23:0] beat);
        result_t got, want;
        got = result_t'(beat[18:0]);
        if (owed_results.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result beat, expected none, got %h", $time, beat);
            return;
        end
        want = owed_results.pop_front();
        if (got.send_valid !== want.send_valid)
            field_err("send_valid", want.send_valid, got.send_valid);
        if (got.send_byte !== want.send_byte)
            field_err("send_byte", want.send_byte, got.send_byte);
        if (got.read_data !== want.read_data)
            field_err("read_data", want.read_data, got.read_data);
        if (got.read_short !== want.read_short)
            field_err("read_short", want.read_short, got.read_short);
        if (got.load_dropped !== want.load_dropped)
            field_err("load_dropped", want.load_dropped, got.load_dropped);
        if (beat[23:19] !== 5'd0)
            field_err("pad bits", 0, beat[23:19]);
    endtask

    // Result side: check each beat, drive m_tready with random stalls,
    // one long hold-off and a calm stretch
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_beat(m_tdata);
                results_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && results_seen == 40)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else if (results_seen >= 300 && results_seen < 450)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Directed table: empty rings, extremes of every field, drops and shorts
    initial
    begin
        plan = '{
            '{OP_READ,      8'h00, 8'h01, 8'h00, 1'b1, RES_SHORT}, // read of empty rx
            '{OP_TRIGGER,   8'h00, 8'h00, 8'h00, 1'b1, RES_NONE},  // trigger on empty tx
            '{OP_XFER_DONE, 8'h00, 8'h00, 8'hFF, 1'b1, RES_NONE},  // rx byte lost
            '{OP_LOAD,      8'hAA, 8'd33, 8'h00, 1'b1, RES_DROP},  // burst just too long
            '{OP_LOAD,      8'hFF, 8'hFF, 8'hFF, 1'b1, RES_DROP},
            '{OP_LOAD,      8'h11, 8'h00, 8'h00, 1'b1, RES_NONE},  // empty burst
            '{OP_LOAD,      8'h00, 8'h01, 8'h00, 1'b1, RES_NONE},
            '{OP_LOAD,      8'hFF, 8'd32, 8'h00, 1'b1, RES_NONE},  // burst at depth
            '{OP_LOAD,      8'h5A, 8'd5,  8'h00, 1'b1, RES_NONE},
            '{OP_TRIGGER,   8'h00, 8'h00, 8'h00, 1'b0, RES_NONE},
            '{OP_XFER_DONE, 8'h00, 8'h00, 8'h00, 1'b0, RES_NONE},
            '{OP_XFER_DONE, 8'h00, 8'h00, 8'hFF, 1'b0, RES_NONE},
            '{OP_TRIGGER,   8'h00, 8'h00, 8'h00, 1'b1, RES_NONE},  // tx drained
            '{OP_READ,      8'h00, 8'h00, 8'h00, 1'b0, RES_NONE},  // count 0 acts as 1
            '{OP_READ,      8'h00, 8'd33, 8'h00, 1'b1, RES_SHORT}, // count above depth
            '{OP_READ,      8'hFF, 8'hFF, 8'hFF, 1'b1, RES_SHORT},
            '{OP_LOAD,      8'h01, 8'd3,  8'h00, 1'b0, RES_NONE},
            '{OP_LOAD,      8'h02, 8'd3,  8'h00, 1'b0, RES_NONE},
            '{OP_XFER_DONE, 8'h00, 8'h00, 8'hA5, 1'b0, RES_NONE},
            '{OP_XFER_DONE, 8'h00, 8'h00, 8'h3C, 1'b0, RES_NONE},
            '{OP_READ,      8'h00, 8'd2,  8'h00, 1'b0, RES_NONE},  // skip one, return next
            '{OP_READ,      8'h00, 8'd2,  8'h00, 1'b1, RES_SHORT}  // ring runs short
        };
    end

    // Stimulus and end of run
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_LOAD;
        m_tready     = 1'b0;
        tx_wr        = 0;
        tx_rd        = 0;
        rx_wr        = 0;
        rx_rd        = 0;
        items_sent   = 0;
        results_seen = 0;
        errors       = 0;
        cycles       = 0;
        hold_left    = 0;
        hold_done    = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].op, plan[i].txb, plan[i].cnt, plan[i].rcv,
                      plan[i].typed, plan[i].want);

        // mostly well-formed bursts, the rest raw noise
        while (items_sent < DIRECTED + RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 70)
                run_burst();
            else
                send_item(op_t'($urandom_range(3)), 8'($urandom), 8'($urandom),
                          8'($urandom), 1'b0, RES_NONE);
        end
        s_tvalid <= 1'b0;

        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("spi_master_ring_buffers_core verification clean");
        else
            $display("spi_master_ring_buffers_core verification failed");
        $finish;
    end

endmodule
